/* rtl/core/dshot4_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the word builder for the four-channel DSHOT encoder.
// No dependencies; every other file of the block imports this package.
package dshot4_pkg;

  localparam int HW_CHANNELS = 4;
  localparam int THROTTLE_W  = 11;
  localparam int DUTY_W      = 10;
  localparam int WORD_W      = 16;
  localparam int SLOT_W      = 5;
  localparam int DATA_BITS   = 16;
  localparam int MAX_TRAIL   = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int ADDR_W      = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [DUTY_W-1:0] ZERO_DUTY_RESET = 10'd225;
  localparam logic [DUTY_W-1:0] ONE_DUTY_RESET  = 10'd450;
  localparam logic [3:0]        CSUM_MASK       = 4'hF;

  // Register index, taken from paddr[2].
  localparam logic REG_ZERO_DUTY = 1'b0;
  localparam logic REG_ONE_DUTY  = 1'b1;

  typedef logic [HW_CHANNELS-1:0][WORD_W-1:0] frame_words_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Packet is throttle and telemetry bit; checksum XORs its three nibbles.
  function automatic logic [WORD_W-1:0] make_word(input logic [THROTTLE_W-1:0] throttle,
                                                  input logic telem);
    logic [11:0] packet;
    logic [3:0]  csum;
    packet = {throttle, telem};
    csum   = (packet[3:0] ^ packet[7:4] ^ packet[11:8]) & CSUM_MASK;
    return {packet, csum};
  endfunction

endpackage

/* rtl/core/dshot4_front.sv */
`timescale 1ns / 1ps
// Input side: unpacks a frame request and builds the DSHOT word of each channel.
// Depends on dshot4_pkg; pushes into dshot4_queue.
module dshot4_front #(
  parameter int ACTIVE_CH = 4
) (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dshot4_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  dshot4_pkg::queue_status_t      status,
  output logic                           push,
  output dshot4_pkg::frame_words_t       words
);
  import dshot4_pkg::*;

  logic [HW_CHANNELS-1:0][THROTTLE_W-1:0] throttle;
  logic                                   telem;

  always_comb begin
    for (int c = 0; c < HW_CHANNELS; c++) begin
      throttle[c] = s_axis_tdata[c*THROTTLE_W +: THROTTLE_W];
    end
    telem = s_axis_tdata[HW_CHANNELS*THROTTLE_W];
  end

  // Channels that are not fitted carry an all-zero word.
  always_comb begin
    for (int c = 0; c < HW_CHANNELS; c++) begin
      words[c] = (c < ACTIVE_CH) ? make_word(throttle[c], telem) : '0;
    end
  end

  assign s_axis_tready = !status.full;
  assign push          = s_axis_tvalid && !status.full;

endmodule

/* rtl/core/dshot4_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of built frames between the input side and the slot sequencer.
// Depends on dshot4_pkg.
module dshot4_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  dshot4_pkg::frame_words_t  push_words,
  input  logic                      pop,
  output dshot4_pkg::frame_words_t  head,
  output dshot4_pkg::queue_status_t status
);
  import dshot4_pkg::*;

  frame_words_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_words;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

endmodule

/* rtl/core/dshot4_back.sv */
`timescale 1ns / 1ps
// Slot sequencer: shifts each frame out MSB first, one bit period per transaction,
// then the trailing low periods. Depends on dshot4_pkg; reads dshot4_queue.
module dshot4_back #(
  parameter int ACTIVE_CH   = 4,
  parameter int TOTAL_SLOTS = 18
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [dshot4_pkg::DUTY_W-1:0]      zero_bit_duty,
  input  logic [dshot4_pkg::DUTY_W-1:0]      one_bit_duty,
  input  dshot4_pkg::frame_words_t           head,
  input  dshot4_pkg::queue_status_t          status,
  output logic                               pop,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [dshot4_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                               m_axis_tlast
);
  import dshot4_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TOTAL_SLOTS - 1);
  localparam logic [SLOT_W-1:0] DATA_END  = SLOT_W'(DATA_BITS);

  frame_words_t                       shreg;
  frame_words_t                       cur;
  logic                               busy;
  logic [SLOT_W-1:0]                  slot;
  logic                               advance;
  logic                               emit;
  logic [HW_CHANNELS-1:0][DUTY_W-1:0] duty_next;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign emit    = advance && (busy || !status.empty);
  assign pop     = advance && !busy && !status.empty;
  assign cur     = busy ? shreg : head;

  always_comb begin
    for (int c = 0; c < HW_CHANNELS; c++) begin
      if (c < ACTIVE_CH && slot < DATA_END) begin
        duty_next[c] = cur[c][WORD_W-1] ? one_bit_duty : zero_bit_duty;
      end else begin
        duty_next[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      slot          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_axis_tvalid <= emit;
      end
      if (emit) begin
        if (slot == LAST_SLOT) begin
          busy <= 1'b0;
          slot <= '0;
        end else begin
          busy <= 1'b1;
          slot <= slot + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int c = 0; c < HW_CHANNELS; c++) begin
        shreg[c] <= {cur[c][WORD_W-2:0], 1'b0};
      end
      m_axis_tdata <= {{(OUT_TDATA_W - HW_CHANNELS*DUTY_W - SLOT_W){1'b0}}, slot,
                       duty_next[3], duty_next[2], duty_next[1], duty_next[0]};
      m_axis_tlast <= (slot == LAST_SLOT);
    end
  end

endmodule

/* rtl/core/dshot_four_channel_frame_encoder.sv */
`timescale 1ns / 1ps
// Top level of the four-channel DSHOT frame encoder: APB registers and the three parts.
// Depends on dshot4_pkg, dshot4_front, dshot4_queue and dshot4_back.
//
// Usage: each transaction on the s_axis channel is one frame request (four 11-bit
// throttle values and a telemetry bit). The block builds the 16-bit DSHOT word of each
// channel and sends one m_axis transaction per bit period, MSB first: four compare
// values (one_bit_duty or zero_bit_duty), the slot index, and tlast on the final
// period. After the 16 data periods come up to two trailing periods with every duty
// at zero, so a frame gives 16 to 18 transactions.
// The first period of a frame passes through a queue entry and then the output register
// when the sequencer is free. Throughput: one period per cycle while m_axis_tready is
// high, set by the slot sequencer; a two-entry frame queue lets requests be taken while
// the previous frame is still being shifted out.
// Reset clears the queue and sequencer and loads the duties with 225 and 450.
// When the receiver holds tready low, the output register holds its transaction and
// the sequencer waits; requests keep being taken until the queue is full.
// Registers: zero_bit_duty at 0x0, one_bit_duty at 0x4; write them only while idle.
module dshot_four_channel_frame_encoder #(
  parameter int CHANNELS    = 4,
  parameter int TRAIL_SLOTS = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // APB configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dshot4_pkg::ADDR_W-1:0]         paddr,
  input  logic [dshot4_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dshot4_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                  pready,
  // Frame requests
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [10:0] throttle_ch1, [21:11] throttle_ch2, [32:22] throttle_ch3,
  // [43:33] throttle_ch4, [44] telemetry_request, [47:45] zero
  input  logic [dshot4_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Bit periods
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [9:0] duty_ch1, [19:10] duty_ch2, [29:20] duty_ch3, [39:30] duty_ch4,
  // [44:40] bit_slot, [47:45] zero
  output logic [dshot4_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                  m_axis_tlast
);
  import dshot4_pkg::*;

  localparam int ACTIVE_CH   = (CHANNELS > HW_CHANNELS) ? HW_CHANNELS : CHANNELS;
  localparam int TRAIL_EFF   = (TRAIL_SLOTS > MAX_TRAIL) ? MAX_TRAIL : TRAIL_SLOTS;
  localparam int TOTAL_SLOTS = DATA_BITS + TRAIL_EFF;

  logic [DUTY_W-1:0] zero_bit_duty;
  logic [DUTY_W-1:0] one_bit_duty;
  logic              wr_en;
  logic              reg_sel;
  logic              push;
  logic              pop;
  frame_words_t      push_words;
  frame_words_t      head;
  queue_status_t     status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_bit_duty <= ZERO_DUTY_RESET;
      one_bit_duty  <= ONE_DUTY_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ZERO_DUTY: zero_bit_duty <= pwdata[DUTY_W-1:0];
        REG_ONE_DUTY:  one_bit_duty  <= pwdata[DUTY_W-1:0];
        default:       zero_bit_duty <= zero_bit_duty;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ZERO_DUTY: prdata = {{(APB_DATA_W - DUTY_W){1'b0}}, zero_bit_duty};
      REG_ONE_DUTY:  prdata = {{(APB_DATA_W - DUTY_W){1'b0}}, one_bit_duty};
      default:       prdata = '0;
    endcase
  end

  dshot4_front #(
    .ACTIVE_CH(ACTIVE_CH)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .status       (status),
    .push         (push),
    .words        (push_words)
  );

  dshot4_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_words(push_words),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  dshot4_back #(
    .ACTIVE_CH  (ACTIVE_CH),
    .TOTAL_SLOTS(TOTAL_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .zero_bit_duty(zero_bit_duty),
    .one_bit_duty (one_bit_duty),
    .head         (head),
    .status       (status),
    .pop          (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule
